>>> rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg: shared types and constants of the insertion sorter
// Store depth, count width, controller states and the command and status
// groups passed between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

  localparam int DEPTH   = 16;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic one_left;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/isort_ctrl.sv
// ----------------------------------------------------------------------------
// isort_ctrl: sequencing controller
// Takes transactions while idle and walks the store out once a batch closes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isort_ctrl
  import isort_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    last,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  state_t state;
  state_t state_next;

  // hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.insert = 1'b1;
          if (last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        busy     = 1'b1;
        cmd.emit = 1'b1;
        if (status.one_left) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/isort_path.sv
// ----------------------------------------------------------------------------
// isort_path: sorting datapath
// A row of cells that stays sorted: each insert compares the new value with
// every cell at once and shifts the larger ones up by one place. Emission
// shifts the row down one place a cycle into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isort_path
  import isort_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire logic signed [31:0] value,
  output status_t                 status,
  output logic signed [31:0]      sorted_value,
  output logic                    last_out,
  output logic                    overflow,
  output logic                    valid
);

  logic signed [VALUE_W-1:0] cells      [DEPTH];
  logic signed [VALUE_W-1:0] cells_next [DEPTH];
  logic [DEPTH-1:0]          gt;
  logic [DEPTH-1:0]          ins;
  logic [FILL_W-1:0]         fill_count;
  logic                      overflow_seen;
  logic                      full;

  assign full            = (fill_count == FILL_W'(DEPTH));
  assign status.one_left = (fill_count == FILL_W'(1));

  // compare the new value with every occupied cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign gt[i]  = (FILL_W'(i) < fill_count) && (cells[i] > value);
    assign ins[i] = gt[i] || (FILL_W'(i) == fill_count);
  end

  // pick each cell's next value
  for (genvar i = 0; i < DEPTH; i++) begin : g_next
    always_comb begin
      cells_next[i] = cells[i];
      if (cmd.emit) begin
        if (i < DEPTH - 1) begin
          cells_next[i] = cells[(i + 1) % DEPTH];
        end
      end else if (cmd.insert && !full) begin
        if (i > 0 && gt[(i + DEPTH - 1) % DEPTH]) begin
          cells_next[i] = cells[(i + DEPTH - 1) % DEPTH];
        end else if (ins[i]) begin
          cells_next[i] = value;
        end
      end
    end
  end

  // advance the cell row
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  // count entries and note dropped values
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.emit) begin
      fill_count <= fill_count - FILL_W'(1);
      if (status.one_left) begin
        overflow_seen <= 1'b0;
      end
    end else if (cmd.insert) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  // register one result per emit cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sorted_value <= cells[0];
      last_out     <= status.one_left;
      overflow     <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

>>> rtl/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter: stable insertion sort of signed 32-bit batches
// Values go into a sorted row of cells; the last value of a batch starts
// emission of the whole batch in nondecreasing order.
// ----------------------------------------------------------------------------
// Insert: one transaction per cycle while busy is low; the parallel compare
//   row places a value in the cycle it is taken.
// Emit: after a last transaction, busy stays high while the N entries held
//   (at most DEPTH) are emitted; results come one per cycle, registered
//   after the state register enters emission. The receiver cannot stall.
// Reset: synchronous; empties the store and clears the overflow mark.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter
  import isort_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] value,
  input  wire logic               last,
  output logic                    valid,
  output logic signed [31:0]      sorted_value,
  output logic                    last_out,
  output logic                    overflow
);

  cmd_t    cmd;
  status_t status;

  isort_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  isort_path u_path (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .status       (status),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow),
    .valid        (valid)
  );

endmodule

`default_nettype wire

>>> rtl/isort_checker.sv
// ----------------------------------------------------------------------------
// isort_checker: port-level checks of the insertion sorter
// Watches the transaction and result ports over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isort_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        last,
  input wire logic        valid,
  input wire logic        last_out,
  input wire logic        overflow
);

  // a closing transaction starts emission
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> busy)
    else $error("busy not raised after last transaction");

  // results only follow an emitting cycle
  a_valid_after_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result without emission");

  // a batch is emitted without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    valid && !last_out |=> valid)
    else $error("gap inside batch emission");

  // the final result finds the block ready again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last_out |-> !busy)
    else $error("busy still high at final result");

  // overflow mark is constant across one batch
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    valid && !last_out |=> overflow == $past(overflow))
    else $error("overflow changed within batch");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .last     (last),
  .valid    (valid),
  .last_out (last_out),
  .overflow (overflow)
);

`default_nettype wire
